@@ hdl/ulsr_pkg.sv @@
`default_nettype none

package ulsr_pkg;

	localparam int KeyWidth = 32;
	localparam int PosWidth = 3;
	localparam int CntWidth = 4;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_INSERT = 2'd1,
		OP_SEARCH = 2'd2,
		OP_REMOVE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	typedef struct packed {
		op_t                        operation;
		logic signed [KeyWidth-1:0] key;
	} in_t;

	typedef struct packed {
		status_t             status;
		logic [PosWidth-1:0] position;
		logic [CntWidth-1:0] entry_count;
	} out_t;

endpackage

`default_nettype wire

@@ hdl/ulsr_ram.sv @@
`default_nettype none

module ulsr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                      clk,
	input  wire logic                      wr_en,
	input  wire logic [ADDR_W-1:0]         wr_addr,
	input  wire logic [WIDTH-1:0]          wr_data,
	input  wire logic                      rd_en,
	input  wire logic [ADDR_W-1:0]         rd_addr,
	output logic      [WIDTH-1:0]          rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

@@ hdl/unsorted_list_search_remove.sv @@
// Unsorted key list with clear, insert, search and remove.
// Request channel: req_valid / req_stall / req (operation, key). A beat is
// taken when req_valid is high and req_stall is low; req_stall is high
// while an operation is in progress. One request at a time.
// Response channel: rsp_valid / rsp_stall / rsp (status, position,
// entry_count). Every request gives exactly one response beat.
// Clear, insert and requests on an empty list go straight to the finish
// state; search scans the stored entries in order until a hit or the end
// of the list; remove scans the same way and then shifts every later
// entry down by one place.
// Scanned plus shifted never exceeds the entry count. The pace is set by
// the single read port of the key memory: one entry is read per cycle
// while scanning and one entry is moved per cycle while shifting.
// Keys live in a one-read, one-write memory with registered read data.
// Reset empties the list at once (the count goes to zero); the memory
// itself is not cleared.
// While rsp_stall holds a response, the next request is still taken and
// worked on; its result waits until the response register frees up.
`default_nettype none

module unsorted_list_search_remove
	import ulsr_pkg::*;
#(
	parameter int CAPACITY = 8
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_stall,
	input  wire in_t  req,
	output logic      rsp_valid,
	input  wire logic rsp_stall,
	output out_t      rsp
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int EW = CW + 1;

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_SCAN   = 4'b0010,
		S_SHIFT  = 4'b0100,
		S_FINISH = 4'b1000
	} state_t;

	state_t                state_q, state_d;
	logic [CW-1:0]         count_q, count_d;
	op_t                   op_q, op_d;
	logic [KeyWidth-1:0]   key_q, key_d;
	logic [AW-1:0]         idx_q, idx_d;
	out_t                  res_q, res_d;
	logic                  rsp_valid_q;
	out_t                  rsp_q;
	logic                  rsp_load;

	logic                  wr_en;
	logic [AW-1:0]         wr_addr;
	logic [KeyWidth-1:0]   wr_data;
	logic                  rd_en;
	logic [AW-1:0]         rd_addr;
	logic [KeyWidth-1:0]   rd_data;

	logic [EW-1:0]         idx_nxt;
	logic [EW-1:0]         idx_nxt2;
	logic [EW-1:0]         count_e;
	logic                  hit;

	ulsr_ram #(
		.WIDTH (KeyWidth),
		.DEPTH (CAPACITY)
	) u_key_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign idx_nxt   = EW'(idx_q) + EW'(1);
	assign idx_nxt2  = EW'(idx_q) + EW'(2);
	assign count_e   = EW'(count_q);
	assign hit       = (rd_data == key_q);
	assign req_stall = (state_q != S_IDLE);
	assign rsp_load  = (state_q == S_FINISH) && (!rsp_valid_q || !rsp_stall);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		state_d = state_q;
		count_d = count_q;
		op_d    = op_q;
		key_d   = key_q;
		idx_d   = idx_q;
		res_d   = res_q;
		wr_en   = 1'b0;
		wr_addr = AW'(count_q);
		wr_data = req.key;
		rd_en   = 1'b0;
		rd_addr = '0;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					op_d           = req.operation;
					key_d          = req.key;
					idx_d          = '0;
					state_d        = S_FINISH;
					res_d.status   = ST_OK;
					res_d.position = '0;
					case (req.operation)
						OP_CLEAR: begin
							count_d = '0;
						end
						OP_INSERT: begin
							if (count_e >= EW'(CAPACITY)) begin
								res_d.status = ST_FULL;
							end else begin
								wr_en          = 1'b1;
								res_d.position = PosWidth'(count_q);
								count_d        = count_q + CW'(1);
							end
						end
						OP_SEARCH, OP_REMOVE: begin
							if (count_q == '0) begin
								res_d.status = ST_EMPTY;
							end else begin
								rd_en   = 1'b1;
								state_d = S_SCAN;
							end
						end
						default: ;
					endcase
					res_d.entry_count = CntWidth'(count_d);
				end
			end
			S_SCAN: begin
				if (hit) begin
					res_d.status   = ST_OK;
					res_d.position = PosWidth'(idx_q);
					if (op_q == OP_REMOVE && idx_nxt < count_e) begin
						rd_en   = 1'b1;
						rd_addr = AW'(idx_nxt);
						state_d = S_SHIFT;
					end else begin
						if (op_q == OP_REMOVE) begin
							count_d = count_q - CW'(1);
						end
						state_d = S_FINISH;
					end
				end else if (idx_nxt < count_e) begin
					rd_en   = 1'b1;
					rd_addr = AW'(idx_nxt);
					idx_d   = AW'(idx_nxt);
				end else begin
					res_d.status   = ST_NOTFOUND;
					res_d.position = '0;
					state_d        = S_FINISH;
				end
				res_d.entry_count = CntWidth'(count_d);
			end
			S_SHIFT: begin
				wr_en   = 1'b1;
				wr_addr = idx_q;
				wr_data = rd_data;
				if (idx_nxt2 < count_e) begin
					rd_en   = 1'b1;
					rd_addr = AW'(idx_nxt2);
					idx_d   = AW'(idx_nxt);
				end else begin
					count_d = count_q - CW'(1);
					state_d = S_FINISH;
				end
				res_d.entry_count = CntWidth'(count_d);
			end
			S_FINISH: begin
				if (rsp_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		op_q  <= op_d;
		key_q <= key_d;
		idx_q <= idx_d;
		res_q <= res_d;
		if (rsp_load) begin
			rsp_q <= res_q;
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_e <= EW'(CAPACITY))
		else $error("entry count above capacity");

	a_scan_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN || state_q == S_SHIFT) |-> (count_q != '0))
		else $error("scan or shift on empty list");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status == ST_EMPTY) |-> (rsp.entry_count == '0))
		else $error("empty status with nonzero count");

	a_shift_after_remove: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHIFT) |-> (op_q == OP_REMOVE))
		else $error("shift outside remove");
`endif

endmodule

`default_nettype wire

@@ tb/sv/unsorted_list_search_remove_tb.sv @@
`timescale 1ns / 1ps

module unsorted_list_search_remove_tb;
	import ulsr_pkg::*;

	localparam int DEPTH       = 8;
	localparam int RANDOM_OPS  = 1200;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_AFTER  = 400;
	localparam int HOLD_CYCLES = 200;
	localparam int NDIR        = 25;

	typedef struct packed {
		in_t  beat;
		logic typed;
		out_t want;
	} dir_row_t;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	in_t  req       = '0;
	logic rsp_stall = 1'b0;
	logic req_stall;
	logic rsp_valid;
	out_t rsp;

	logic [KeyWidth-1:0] list_keys [DEPTH];
	int                  list_fill = 0;
	logic [KeyWidth-1:0] key_pool [6];

	out_t pending_results [$];
	int   errors          = 0;
	int   cycle_count     = 0;
	int   items_accepted  = 0;
	int   burst_left      = 0;
	int   long_hold_done  = 0;
	int   op_count [4]    = '{0, 0, 0, 0};
	int   status_count [4] = '{0, 0, 0, 0};

	dir_row_t directed_rows [NDIR] = '{
		'{'{OP_SEARCH, 32'h00000000}, 1'b1, '{ST_EMPTY,    3'd0, 4'd0}},
		'{'{OP_REMOVE, 32'h00000000}, 1'b1, '{ST_EMPTY,    3'd0, 4'd0}},
		'{'{OP_INSERT, 32'h80000000}, 1'b1, '{ST_OK,       3'd0, 4'd1}},
		'{'{OP_INSERT, 32'h7fffffff}, 1'b1, '{ST_OK,       3'd1, 4'd2}},
		'{'{OP_INSERT, 32'h00000000}, 1'b1, '{ST_OK,       3'd2, 4'd3}},
		'{'{OP_INSERT, 32'hffffffff}, 1'b1, '{ST_OK,       3'd3, 4'd4}},
		'{'{OP_INSERT, 32'h00000005}, 1'b1, '{ST_OK,       3'd4, 4'd5}},
		'{'{OP_INSERT, 32'h00000005}, 1'b1, '{ST_OK,       3'd5, 4'd6}},
		'{'{OP_INSERT, 32'haaaaaaaa}, 1'b1, '{ST_OK,       3'd6, 4'd7}},
		'{'{OP_INSERT, 32'h55555555}, 1'b1, '{ST_OK,       3'd7, 4'd8}},
		'{'{OP_INSERT, 32'h00000123}, 1'b1, '{ST_FULL,     3'd0, 4'd8}},
		'{'{OP_SEARCH, 32'h00000005}, 1'b0, '0},
		'{'{OP_SEARCH, 32'h00000099}, 1'b1, '{ST_NOTFOUND, 3'd0, 4'd8}},
		'{'{OP_REMOVE, 32'h00000005}, 1'b0, '0},
		'{'{OP_SEARCH, 32'h00000005}, 1'b0, '0},
		'{'{OP_REMOVE, 32'h80000000}, 1'b0, '0},
		'{'{OP_REMOVE, 32'h55555555}, 1'b0, '0},
		'{'{OP_REMOVE, 32'h00000099}, 1'b1, '{ST_NOTFOUND, 3'd0, 4'd5}},
		'{'{OP_SEARCH, 32'hffffffff}, 1'b0, '0},
		'{'{OP_SEARCH, 32'h7fffffff}, 1'b0, '0},
		'{'{OP_CLEAR,  32'h00000000}, 1'b1, '{ST_OK,       3'd0, 4'd0}},
		'{'{OP_SEARCH, 32'h00000005}, 1'b1, '{ST_EMPTY,    3'd0, 4'd0}},
		'{'{OP_INSERT, 32'h00000042}, 1'b1, '{ST_OK,       3'd0, 4'd1}},
		'{'{OP_REMOVE, 32'h00000042}, 1'b0, '0},
		'{'{OP_REMOVE, 32'h00000042}, 1'b1, '{ST_EMPTY,    3'd0, 4'd0}}
	};

	unsorted_list_search_remove #(
		.CAPACITY(DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always #5 clk = ~clk;

	function automatic int find_key(logic [KeyWidth-1:0] k);
		for (int i = 0; i < list_fill; i++) begin
			if (list_keys[i] == k)
				return i;
		end
		return -1;
	endfunction

	function automatic out_t apply_list_op(in_t beat);
		out_t res;
		int   hit;
		res = '0;
		res.status = ST_OK;
		case (beat.operation)
			OP_CLEAR: begin
				list_fill = 0;
			end
			OP_INSERT: begin
				if (list_fill >= DEPTH) begin
					res.status = ST_FULL;
				end else begin
					list_keys[list_fill] = beat.key;
					res.position = PosWidth'(list_fill);
					list_fill++;
				end
			end
			default: begin
				if (list_fill == 0) begin
					res.status = ST_EMPTY;
				end else begin
					hit = find_key(beat.key);
					if (hit < 0) begin
						res.status = ST_NOTFOUND;
					end else begin
						res.position = PosWidth'(hit);
						if (beat.operation == OP_REMOVE) begin
							for (int i = hit; i + 1 < list_fill; i++)
								list_keys[i] = list_keys[i + 1];
							list_fill--;
						end
					end
				end
			end
		endcase
		res.entry_count = CntWidth'(list_fill);
		return res;
	endfunction

	function automatic logic [KeyWidth-1:0] pick_key();
		int r;
		r = $urandom_range(0, 9);
		if (list_fill > 0 && r < 5)
			return list_keys[$urandom_range(0, list_fill - 1)];
		if (r < 8)
			return key_pool[$urandom_range(0, 5)];
		return $urandom;
	endfunction

	task automatic offer(in_t beat, logic typed, out_t want);
		int   gap;
		out_t predicted;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				@(negedge clk);
				req_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
				: $urandom_range(1, 8);
		end
		@(negedge clk);
		req       <= beat;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall !== 1'b0)
			@(posedge clk);
		burst_left--;
		items_accepted++;
		predicted = apply_list_op(beat);
		if (typed)
			predicted = want;
		op_count[beat.operation]++;
		status_count[predicted.status]++;
		pending_results.push_back(predicted);
	endtask

	always @(posedge clk) begin
		out_t want;
		if (arst_n && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected response, expected none, got %h", $time, rsp);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (rsp.status !== want.status) begin
					$display("%0t: status mismatch, expected %0d, got %0d",
						$time, want.status, rsp.status);
					errors++;
				end
				if (rsp.position !== want.position) begin
					$display("%0t: position mismatch, expected %0d, got %0d",
						$time, want.position, rsp.position);
					errors++;
				end
				if (rsp.entry_count !== want.entry_count) begin
					$display("%0t: entry_count mismatch, expected %0d, got %0d",
						$time, want.entry_count, rsp.entry_count);
					errors++;
				end
			end
		end
	end

	initial begin
		int mode;
		int len;
		@(posedge arst_n);
		forever begin
			if (long_hold_done == 0 && items_accepted >= HOLD_AFTER) begin
				@(negedge clk);
				rsp_stall <= 1'b1;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				long_hold_done = 1;
			end else begin
				mode = $urandom_range(0, 2);
				len  = $urandom_range(10, 60);
				repeat (len) begin
					@(negedge clk);
					case (mode)
						0: rsp_stall <= 1'b0;
						1: rsp_stall <= ($urandom_range(0, 2) == 0);
						default: rsp_stall <= ($urandom_range(0, 3) != 0);
					endcase
				end
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("%0t: timeout with %0d responses outstanding", $time,
			pending_results.size());
		$display("** unsorted_list_search_remove: FAILED **");
		$finish;
	end

	initial begin
		in_t beat;
		int  r;
		int  fill_phase;
		key_pool[0] = 32'h80000000;
		key_pool[1] = 32'h7fffffff;
		key_pool[2] = 32'h00000000;
		key_pool[3] = 32'hffffffff;
		key_pool[4] = $urandom;
		key_pool[5] = $urandom;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			offer(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].want);

		for (int i = 0; i < RANDOM_OPS; i++) begin
			fill_phase = ((i / 40) % 2) == 0;
			r = $urandom_range(0, 99);
			if (r < 3)
				beat.operation = OP_CLEAR;
			else if (r < (fill_phase ? 60 : 30))
				beat.operation = OP_INSERT;
			else if (r < (fill_phase ? 80 : 55))
				beat.operation = OP_SEARCH;
			else
				beat.operation = OP_REMOVE;
			beat.key = pick_key();
			offer(beat, 1'b0, '0);
		end
		@(negedge clk);
		req_valid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (2 * DEPTH + 8) @(posedge clk);

		$display("requests: %0d clear, %0d insert, %0d search, %0d remove",
			op_count[OP_CLEAR], op_count[OP_INSERT], op_count[OP_SEARCH],
			op_count[OP_REMOVE]);
		$display("outcomes: %0d ok, %0d full, %0d empty, %0d not found",
			status_count[ST_OK], status_count[ST_FULL], status_count[ST_EMPTY],
			status_count[ST_NOTFOUND]);
		if (errors == 0)
			$display("** unsorted_list_search_remove: PASSED **");
		else
			$display("** unsorted_list_search_remove: FAILED **");
		$finish;
	end

endmodule
